>>> hw/rtl/rcm_pkg.sv
`timescale 1ns / 1ps

package rcm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 32;
	localparam int DELTA_W  = 33;
	localparam int CM_W     = 64;
	localparam int CNT_W    = 16;
	localparam int IDX_W    = 2;
	localparam int STAT_W   = 2;
	localparam int PROD_W   = 64;
	localparam int Q_W      = 48;

	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

>>> hw/rtl/running_covariance_matrix.sv
`timescale 1ns / 1ps

// Welford running mean and covariance over DIM-element vectors of signed 16-bit
// samples. In an update transaction (cmd 0), one comoment lane per upper-triangle
// entry and one mean lane per element run side by side, and the pace is set by the
// 48-step serial divide by the new count in each comoment lane. A read transaction
// (cmd 1) is paced by the 64-step serial divide of the selected comoment by count
// minus one. One transaction is processed at a time; a new one is accepted while
// the previous result still waits in the output register.
// Means are Q16.16, covariance carries 16 fractional bits, comoments saturate.
module running_covariance_matrix #(
	parameter int DIM = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0] sample_0,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0] sample_1,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0] sample_2,
	input  logic signed [rcm_pkg::SAMPLE_W-1:0] sample_3,
	input  logic [rcm_pkg::IDX_W-1:0]           row_index,
	input  logic [rcm_pkg::IDX_W-1:0]           col_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rcm_pkg::CNT_W-1:0]           sample_count,
	output logic signed [rcm_pkg::MEAN_W-1:0]   mean_row,
	output logic signed [rcm_pkg::MEAN_W-1:0]   mean_col,
	output logic signed [rcm_pkg::CM_W-1:0]     covariance,
	output logic [rcm_pkg::STAT_W-1:0]          status
);

	localparam int NTRI = (DIM * (DIM + 1)) / 2;
	localparam int NIN  = 4;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [1:0]                            state_q;
	logic                                  cmd_q;
	logic [rcm_pkg::IDX_W-1:0]             row_q;
	logic [rcm_pkg::IDX_W-1:0]             col_q;
	logic [rcm_pkg::CNT_W-1:0]             count_q;
	logic [rcm_pkg::CNT_W-1:0]             n_next;
	logic signed [rcm_pkg::MEAN_W-1:0]     mean_q [DIM];
	logic [rcm_pkg::DELTA_W-1:0]           d_q [DIM];
	logic [rcm_pkg::MEAN_W-1:0]            dmag [DIM];
	logic [rcm_pkg::MEAN_W-1:0]            mquo [DIM];
	logic [DIM-1:0]                        mbusy;
	logic signed [rcm_pkg::SAMPLE_W-1:0]   samp [NIN];
	logic signed [rcm_pkg::CM_W-1:0]       lane_cm [NTRI];
	logic [NTRI-1:0]                       lane_busy;
	logic [NTRI-1:0]                       hit;
	logic [rcm_pkg::IDX_W-1:0]             lo;
	logic [rcm_pkg::IDX_W-1:0]             hi;
	logic                                  pair_ok;
	logic signed [rcm_pkg::CM_W-1:0]       cm_sel;
	logic [rcm_pkg::CM_W-1:0]              cm_mag;
	logic [rcm_pkg::CM_W-1:0]              rquo;
	logic                                  rbusy;
	logic signed [rcm_pkg::MEAN_W-1:0]     mr_sel;
	logic signed [rcm_pkg::MEAN_W-1:0]     mc_sel;
	logic                                  accept;
	logic                                  full;
	logic                                  upd_start;
	logic                                  all_done;
	logic                                  out_load;

	logic [rcm_pkg::CNT_W-1:0]             res_cnt_q;
	logic signed [rcm_pkg::MEAN_W-1:0]     res_mr_q;
	logic signed [rcm_pkg::MEAN_W-1:0]     res_mc_q;
	logic signed [rcm_pkg::CM_W-1:0]       res_cov_q;
	logic [rcm_pkg::STAT_W-1:0]            res_st_q;

	logic                                  out_valid_q;
	logic [rcm_pkg::CNT_W-1:0]             cnt_out_q;
	logic signed [rcm_pkg::MEAN_W-1:0]     mr_out_q;
	logic signed [rcm_pkg::MEAN_W-1:0]     mc_out_q;
	logic signed [rcm_pkg::CM_W-1:0]       cov_out_q;
	logic [rcm_pkg::STAT_W-1:0]            st_out_q;

	assign samp[0] = sample_0;
	assign samp[1] = sample_1;
	assign samp[2] = sample_2;
	assign samp[3] = sample_3;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign full      = count_q == rcm_pkg::COUNT_MAX;
	assign n_next    = count_q + rcm_pkg::CNT_W'(1);
	assign upd_start = state_q == S_START && cmd_q == rcm_pkg::CMD_UPDATE;
	assign all_done  = !(|mbusy) && !(|lane_busy) && !rbusy;
	assign out_load  = state_q == S_OUT && (!out_valid_q || out_ready);

	// Mean lanes: delta against the old mean, then delta / n.
	for (genvar i = 0; i < DIM; i++) begin : g_mean
		logic [rcm_pkg::DELTA_W-1:0] s_ext;
		logic [rcm_pkg::DELTA_W-1:0] d_new;
		logic [rcm_pkg::DELTA_W-1:0] d_neg;

		if (i < NIN) begin : g_in
			assign s_ext = {samp[i][rcm_pkg::SAMPLE_W-1], samp[i], 16'h0000};
		end else begin : g_zero
			assign s_ext = '0;
		end

		assign d_new = s_ext - {mean_q[i][rcm_pkg::MEAN_W-1], mean_q[i]};
		assign d_neg = -d_q[i];
		assign dmag[i] = d_q[i][rcm_pkg::DELTA_W-1] ? d_neg[rcm_pkg::MEAN_W-1:0]
							: d_q[i][rcm_pkg::MEAN_W-1:0];

		always_ff @(posedge clk) begin
			if (accept) d_q[i] <= d_new;
		end

		rcm_div #(.W(rcm_pkg::MEAN_W)) u_mdiv (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (upd_start),
			.dividend (dmag[i]),
			.divisor  (n_next),
			.quotient (mquo[i]),
			.busy     (mbusy[i])
		);
	end

	// Comoment lanes, upper triangle in row-major order.
	for (genvar i = 0; i < DIM; i++) begin : g_row
		for (genvar j = i; j < DIM; j++) begin : g_col
			localparam int K = i * DIM - (i * (i - 1)) / 2 + (j - i);

			rcm_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (upd_start),
				.mag_a  (dmag[i]),
				.mag_b  (dmag[j]),
				.neg    (d_q[i][rcm_pkg::DELTA_W-1] ^ d_q[j][rcm_pkg::DELTA_W-1]),
				.n      (n_next),
				.cm     (lane_cm[K]),
				.busy   (lane_busy[K])
			);

			assign hit[K] = (32'(lo) == i) && (32'(hi) == j);
		end
	end

	// Read side: select the comoment and the two means.
	assign lo = (row_q < col_q) ? row_q : col_q;
	assign hi = (row_q < col_q) ? col_q : row_q;
	assign pair_ok = 32'(hi) < DIM;

	always_comb begin
		cm_sel = '0;
		for (int k = 0; k < NTRI; k++) begin
			if (hit[k]) cm_sel = lane_cm[k];
		end
		mr_sel = '0;
		mc_sel = '0;
		for (int i = 0; i < DIM; i++) begin
			if (32'(row_q) == i) mr_sel = mean_q[i];
			if (32'(col_q) == i) mc_sel = mean_q[i];
		end
	end

	assign cm_mag = cm_sel[rcm_pkg::CM_W-1] ? -cm_sel : cm_sel;

	rcm_div #(.W(rcm_pkg::CM_W)) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START && cmd_q == rcm_pkg::CMD_READ),
		.dividend (cm_mag),
		.divisor  (count_q - rcm_pkg::CNT_W'(1)),
		.quotient (rquo),
		.busy     (rbusy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			for (int i = 0; i < DIM; i++) mean_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == rcm_pkg::CMD_UPDATE && full) state_q <= S_OUT;
						else state_q <= S_START;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (all_done) begin
						state_q <= S_OUT;
						if (cmd_q == rcm_pkg::CMD_UPDATE) begin
							count_q <= n_next;
							for (int i = 0; i < DIM; i++) begin
								mean_q[i] <= mean_q[i] + (d_q[i][rcm_pkg::DELTA_W-1]
									? -mquo[i] : mquo[i]);
							end
						end
					end
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			row_q <= row_index;
			col_q <= col_index;
			if (cmd == rcm_pkg::CMD_UPDATE && full) begin
				res_cnt_q <= rcm_pkg::COUNT_MAX;
				res_mr_q  <= '0;
				res_mc_q  <= '0;
				res_cov_q <= '0;
				res_st_q  <= rcm_pkg::ST_FULL;
			end
		end else if (state_q == S_WAIT && all_done) begin
			if (cmd_q == rcm_pkg::CMD_UPDATE) begin
				res_cnt_q <= n_next;
				res_mr_q  <= '0;
				res_mc_q  <= '0;
				res_cov_q <= '0;
				res_st_q  <= rcm_pkg::ST_OK;
			end else begin
				res_cnt_q <= count_q;
				res_mr_q  <= mr_sel;
				res_mc_q  <= mc_sel;
				if (count_q < rcm_pkg::CNT_W'(2)) begin
					res_cov_q <= '0;
					res_st_q  <= rcm_pkg::ST_FEW;
				end else begin
					res_cov_q <= !pair_ok ? '0 : (cm_sel[rcm_pkg::CM_W-1] ? -rquo : rquo);
					res_st_q  <= rcm_pkg::ST_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cnt_out_q <= res_cnt_q;
			mr_out_q  <= res_mr_q;
			mc_out_q  <= res_mc_q;
			cov_out_q <= res_cov_q;
			st_out_q  <= res_st_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_count = cnt_out_q;
	assign mean_row     = mr_out_q;
	assign mean_col     = mc_out_q;
	assign covariance   = cov_out_q;
	assign status       = st_out_q;

endmodule

>>> hw/rtl/rcm_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module rcm_div #(
	parameter int W = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [W-1:0]                 dividend,
	input  logic [rcm_pkg::CNT_W-1:0]    divisor,
	output logic [W-1:0]                 quotient,
	output logic                         busy
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0]               cnt_q;
	logic [rcm_pkg::CNT_W-1:0]   rem_q;
	logic [rcm_pkg::CNT_W-1:0]   div_q;
	logic [W-1:0]                quo_q;
	logic [rcm_pkg::CNT_W:0]     trial;
	logic [rcm_pkg::CNT_W:0]     diff;
	logic                        ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[rcm_pkg::CNT_W-1:0] : trial[rcm_pkg::CNT_W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign busy     = cnt_q != '0;

endmodule

>>> hw/rtl/rcm_lane.sv
`timescale 1ns / 1ps

// One comoment entry: multiply the two delta magnitudes, scale by (n-1)/n
// through a serial divide, then accumulate with saturation.
module rcm_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rcm_pkg::MEAN_W-1:0]        mag_a,
	input  logic [rcm_pkg::MEAN_W-1:0]        mag_b,
	input  logic                              neg,
	input  logic [rcm_pkg::CNT_W-1:0]         n,
	output logic signed [rcm_pkg::CM_W-1:0]   cm,
	output logic                              busy
);

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_KICK = 2'd1;
	localparam logic [1:0] L_WAIT = 2'd2;

	logic [1:0]                      st_q;
	logic [rcm_pkg::PROD_W-1:0]      prod_s1;
	logic                            neg_q;
	logic [rcm_pkg::CNT_W-1:0]       n_q;
	logic [rcm_pkg::Q_W-1:0]         q;
	logic [rcm_pkg::Q_W-1:0]         quo;
	logic [rcm_pkg::Q_W-1:0]         m;
	logic                            div_busy;
	logic [rcm_pkg::CM_W:0]          inc;
	logic [rcm_pkg::CM_W:0]          sum;
	logic signed [rcm_pkg::CM_W-1:0] cm_q;

	assign q = prod_s1[rcm_pkg::PROD_W-1:16];

	rcm_div #(.W(rcm_pkg::Q_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (st_q == L_KICK),
		.dividend (q),
		.divisor  (n_q),
		.quotient (quo),
		.busy     (div_busy)
	);

	assign m   = q - quo;
	assign inc = neg_q ? -{17'd0, m} : {17'd0, m};
	assign sum = {cm_q[rcm_pkg::CM_W-1], cm_q} + inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			cm_q <= '0;
		end else begin
			unique case (st_q)
				L_IDLE: begin
					if (start) st_q <= L_KICK;
				end
				L_KICK: st_q <= L_WAIT;
				L_WAIT: begin
					if (!div_busy) begin
						st_q <= L_IDLE;
						if (sum[rcm_pkg::CM_W] != sum[rcm_pkg::CM_W-1])
							cm_q <= sum[rcm_pkg::CM_W] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
						else
							cm_q <= sum[rcm_pkg::CM_W-1:0];
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && st_q == L_IDLE) begin
			prod_s1 <= mag_a * mag_b;
			neg_q   <= neg;
			n_q     <= n;
		end
	end

	assign cm   = cm_q;
	assign busy = st_q != L_IDLE;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int DIM = 4;
	localparam int NTRI = DIM * (DIM + 1) / 2;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic                                cmd;
		logic signed [rcm_pkg::SAMPLE_W-1:0] smp [4];
		logic [rcm_pkg::IDX_W-1:0]           row;
		logic [rcm_pkg::IDX_W-1:0]           col;
	} stats_req_t;

	typedef struct {
		logic [rcm_pkg::CNT_W-1:0]         cnt;
		logic signed [rcm_pkg::MEAN_W-1:0] mrow;
		logic signed [rcm_pkg::MEAN_W-1:0] mcol;
		logic signed [rcm_pkg::CM_W-1:0]   cov;
		logic [rcm_pkg::STAT_W-1:0]        st;
	} stats_rsp_t;

	typedef struct {
		stats_req_t req;
		bit         fixed;
		stats_rsp_t rsp;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = rcm_pkg::CMD_UPDATE;
	logic signed [rcm_pkg::SAMPLE_W-1:0] sample_0 = '0, sample_1 = '0;
	logic signed [rcm_pkg::SAMPLE_W-1:0] sample_2 = '0, sample_3 = '0;
	logic [rcm_pkg::IDX_W-1:0] row_index = '0, col_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [rcm_pkg::CNT_W-1:0] sample_count;
	logic signed [rcm_pkg::MEAN_W-1:0] mean_row, mean_col;
	logic signed [rcm_pkg::CM_W-1:0] covariance;
	logic [rcm_pkg::STAT_W-1:0] status;

	// Predictor state.
	logic [rcm_pkg::CNT_W-1:0]         model_count;
	logic signed [rcm_pkg::MEAN_W-1:0] model_mean [DIM];
	logic signed [rcm_pkg::CM_W-1:0]   model_cm [NTRI];

	stats_rsp_t pending_rsp [$];
	table_row_t dir_rows [$];
	int errors = 0;
	int n_updates = 0, n_reads = 0, n_full = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	running_covariance_matrix #(.DIM(DIM)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .sample_0(sample_0), .sample_1(sample_1),
		.sample_2(sample_2), .sample_3(sample_3),
		.row_index(row_index), .col_index(col_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_count(sample_count), .mean_row(mean_row), .mean_col(mean_col),
		.covariance(covariance), .status(status)
	);

	function automatic int tri_slot(int i, int j);
		int t;
		if (i > j) begin
			t = i;
			i = j;
			j = t;
		end
		return i * DIM - (i * (i - 1)) / 2 + (j - i);
	endfunction

	task automatic welford_step(input stats_req_t req, output stats_rsp_t rsp);
		longint signed d [DIM];
		longint unsigned n, a, b, q, m;
		logic signed [65:0] sum;
		int k;
		rsp = '{cnt: '0, mrow: '0, mcol: '0, cov: '0, st: rcm_pkg::ST_OK};
		if (req.cmd == rcm_pkg::CMD_UPDATE) begin
			n_updates++;
			if (model_count == rcm_pkg::COUNT_MAX) begin
				rsp.cnt = rcm_pkg::COUNT_MAX;
				rsp.st = rcm_pkg::ST_FULL;
				n_full++;
				return;
			end
			n = model_count + 1;
			for (int i = 0; i < DIM; i++)
				d[i] = (longint'(req.smp[i]) <<< 16) - longint'(model_mean[i]);
			for (int i = 0; i < DIM; i++) begin
				for (int j = i; j < DIM; j++) begin
					a = d[i] < 0 ? -d[i] : d[i];
					b = d[j] < 0 ? -d[j] : d[j];
					q = (((a >> 16) * (b >> 16)) << 16) + (a >> 16) * (b & 16'hFFFF)
						+ (a & 16'hFFFF) * (b >> 16) + (((a & 16'hFFFF) * (b & 16'hFFFF)) >> 16);
					m = q - q / n;
					k = tri_slot(i, j);
					sum = ((d[i] < 0) != (d[j] < 0)) ? 66'(model_cm[k]) - $signed({2'b0, m})
						: 66'(model_cm[k]) + $signed({2'b0, m});
					if (sum > 66'sh0_7FFF_FFFF_FFFF_FFFF)
						model_cm[k] = 64'h7FFF_FFFF_FFFF_FFFF;
					else if (sum < -66'sh0_8000_0000_0000_0000)
						model_cm[k] = 64'h8000_0000_0000_0000;
					else
						model_cm[k] = sum[63:0];
				end
			end
			for (int i = 0; i < DIM; i++)
				model_mean[i] = 32'(longint'(model_mean[i]) + d[i] / longint'(n));
			model_count = 16'(n);
			rsp.cnt = model_count;
		end else begin
			n_reads++;
			rsp.cnt = model_count;
			rsp.mrow = model_mean[req.row];
			rsp.mcol = model_mean[req.col];
			if (model_count < 2)
				rsp.st = rcm_pkg::ST_FEW;
			else
				rsp.cov = model_cm[tri_slot(req.row, req.col)] / longint'(model_count - 1);
		end
	endtask

	// Sends one transaction and returns once it has been accepted.
	task automatic send(input stats_req_t req, input bit fixed, input stats_rsp_t want);
		stats_rsp_t rsp;
		if (!quiet && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= req.cmd;
		sample_0 <= req.smp[0];
		sample_1 <= req.smp[1];
		sample_2 <= req.smp[2];
		sample_3 <= req.smp[3];
		row_index <= req.row;
		col_index <= req.col;
		do @(posedge clk); while (!in_ready);
		welford_step(req, rsp);
		pending_rsp.push_back(fixed ? want : rsp);
	endtask

	function automatic logic signed [rcm_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return 16'($urandom_range(40)) - 16'sd20;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic stats_req_t rand_req(input int read_pct);
		stats_req_t r;
		r.cmd = ($urandom_range(99) < read_pct) ? rcm_pkg::CMD_READ : rcm_pkg::CMD_UPDATE;
		for (int i = 0; i < 4; i++)
			r.smp[i] = rand_sample();
		r.row = rcm_pkg::IDX_W'($urandom);
		r.col = rcm_pkg::IDX_W'($urandom);
		return r;
	endfunction

	function automatic table_row_t mk_row(input logic c, input int s0, input int s1, input int s2,
			input int s3, input int r, input int cl, input bit fixed = 1'b0,
			input stats_rsp_t want = '{cnt: '0, mrow: '0, mcol: '0, cov: '0,
				st: rcm_pkg::ST_OK});
		table_row_t t;
		t.req.cmd = c;
		t.req.smp = '{16'(s0), 16'(s1), 16'(s2), 16'(s3)};
		t.req.row = rcm_pkg::IDX_W'(r);
		t.req.col = rcm_pkg::IDX_W'(cl);
		t.fixed = fixed;
		t.rsp = want;
		return t;
	endfunction

	always @(posedge clk)
		out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with nothing expected: count %0d status %0d",
					$time, sample_count, status);
				errors++;
			end else begin
				stats_rsp_t e;
				e = pending_rsp.pop_front();
				if (sample_count !== e.cnt) begin
					$display("%0t: sample_count expected %0d actual %0d", $time, e.cnt, sample_count);
					errors++;
				end
				if (mean_row !== e.mrow) begin
					$display("%0t: mean_row expected %h actual %h", $time, e.mrow, mean_row);
					errors++;
				end
				if (mean_col !== e.mcol) begin
					$display("%0t: mean_col expected %h actual %h", $time, e.mcol, mean_col);
					errors++;
				end
				if (covariance !== e.cov) begin
					$display("%0t: covariance expected %h actual %h", $time, e.cov, covariance);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		stats_rsp_t none;
		none = '{cnt: '0, mrow: '0, mcol: '0, cov: '0, st: rcm_pkg::ST_OK};
		model_count = '0;
		foreach (model_mean[i]) model_mean[i] = '0;
		foreach (model_cm[i]) model_cm[i] = '0;

		// Directed table; only the first few rows carry typed-in results.
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1'b1,
			'{cnt: 16'd0, mrow: '0, mcol: '0, cov: '0, st: rcm_pkg::ST_FEW}));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_UPDATE, 32767, -32768, 0, -1, 0, 0, 1'b1,
			'{cnt: 16'd1, mrow: '0, mcol: '0, cov: '0, st: rcm_pkg::ST_OK}));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 1'b1,
			'{cnt: 16'd1, mrow: 32'h7FFF_0000, mcol: 32'h8000_0000, cov: '0,
				st: rcm_pkg::ST_FEW}));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 3, 2, 1'b1,
			'{cnt: 16'd1, mrow: 32'hFFFF_0000, mcol: '0, cov: '0, st: rcm_pkg::ST_FEW}));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_UPDATE, -32768, 32767, -1, 0, 0, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 0, 1));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 1, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 3, 3));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 2, 3));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_UPDATE, 32767, 32767, 32767, 32767, 0, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_UPDATE, -32768, -32768, -32768, -32768, 0, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_UPDATE, 1, -1, 12345, -12345, 0, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 1, 2));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 3, 0));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 2, 2));
		dir_rows.push_back(mk_row(rcm_pkg::CMD_READ, 0, 0, 0, 0, 1, 3));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

		for (int i = 0; i < 1470; i++) begin
			quiet = (i >= 600 && i < 900);
			send(rand_req(40), 1'b0, none);
		end
		quiet = 1'b0;

		// Hold off until the block has drained completely.
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);

		for (int i = 0; i < 12; i++)
			send(rand_req(50), 1'b0, none);
		in_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d updates and %0d reads with stalls on both sides, up to %0d samples.",
			n_updates, n_reads, model_count);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
